/* hdl/dlm_pkg.sv */
package dlm_pkg;

  localparam int unsigned LogFrac = 16;
  // normalize stage, one squaring stage per fraction bit, scale stage
  localparam int unsigned LogLat  = LogFrac + 2;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [63:0] ONE_Q16 = 64'd65536;

  localparam logic [7:0] CFG_TF_SCALE      = 8'd0;
  localparam logic [7:0] CFG_MU_RECIPROCAL = 8'd1;
  localparam logic [7:0] CFG_CONST_BOOST   = 8'd2;
  localparam logic [7:0] CFG_USE_ITEM      = 8'd3;
  localparam logic [7:0] CFG_MERGE_MODE    = 8'd4;

  typedef enum logic [1:0] {
    MERGE_ASSIGN = 2'd0,
    MERGE_ADD    = 2'd1,
    MERGE_MAX    = 2'd2
  } merge_e;

  typedef struct packed {
    logic [31:0] term_freq;
    logic [31:0] doc_length;
    logic [31:0] item_boost;
    logic [31:0] prior_score;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [31:0] score;
    logic        last_out;
  } out_t;

endpackage

/* hdl/dlm_log1p.sv */
module dlm_log1p
  import dlm_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  output logic [31:0] y_o
);

  logic [63:0] y_sum;
  logic [5:0]  top_pos;
  logic [31:0] mant;

  logic [31:0] m_q    [0:LogFrac];
  logic [5:0]  p_q    [0:LogFrac];
  logic [15:0] frac_q [0:LogFrac];
  logic [31:0] res_q;

  always_comb begin
    y_sum = (x_i > (64'hFFFF_FFFF_FFFF_FFFF - ONE_Q16)) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                         : x_i + ONE_Q16;
    top_pos = 6'd0;
    for (int b = 0; b < 64; b++) begin
      if (y_sum[b]) top_pos = 6'(b);
    end
    if (top_pos >= 6'd31) mant = 32'(y_sum >> (top_pos - 6'd31));
    else                  mant = 32'(y_sum << (6'd31 - top_pos));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]    <= mant;
      p_q[0]    <= top_pos;
      frac_q[0] <= '0;
    end
  end

  // one fraction bit per stage by squaring the mantissa
  for (genvar k = 0; k < LogFrac; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] sh;
    logic [31:0] m_d;
    logic [15:0] frac_d;
    always_comb begin
      sq     = m_q[k] * m_q[k];
      sh     = sq[63:31];
      frac_d = frac_q[k];
      if (sh[32]) begin
        m_d = sh[32:1];
        frac_d[LogFrac-1-k] = 1'b1;
      end else begin
        m_d = sh[31:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k+1]    <= m_d;
        p_q[k+1]    <= p_q[k];
        frac_q[k+1] <= frac_d;
      end
    end
  end

  logic [21:0] l2;
  logic [54:0] prod;
  always_comb begin
    l2   = {p_q[LogFrac] - 6'd16, frac_q[LogFrac]};
    prod = 55'(l2) * 55'(LN2_Q32) + 55'h8000_0000;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= {9'd0, prod[54:32]};
  end

  assign y_o = res_q;

endmodule

/* hdl/dirichlet_lm_score.sv */
// Dirichlet-smoothed query-likelihood scorer. Each transfer on the input
// channel yields exactly one result: log1p(tf*tf_scale) - log1p(doclen*mu_recip)
// clamped at zero, times the boost, merged with the prior score. One posting is
// taken per cycle unless stalled; the 16 squaring stages of the log units form
// most of the depth. The whole pipeline holds while the output register waits, so
// in_ready_o follows out_ready_i whenever a result is pending. Config writes are
// always taken and must only happen while the pipeline is empty.
module dirichlet_lm_score
  import dlm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic [47:0] tf_scale_q;
  logic [31:0] mu_recip_q;
  logic [31:0] const_boost_q;
  logic        use_item_q;
  logic [1:0]  merge_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tf_scale_q    <= 48'd65536;
      mu_recip_q    <= 32'd2147483;
      const_boost_q <= 32'd65536;
      use_item_q    <= 1'b0;
      merge_mode_q  <= MERGE_ASSIGN;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TF_SCALE:      tf_scale_q    <= cfg_data_i;
        CFG_MU_RECIPROCAL: mu_recip_q    <= cfg_data_i[31:0];
        CFG_CONST_BOOST:   const_boost_q <= cfg_data_i[31:0];
        CFG_USE_ITEM:      use_item_q    <= cfg_data_i[0];
        CFG_MERGE_MODE:    merge_mode_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic in_xfer;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign in_xfer    = in_valid_i && en;

  // stage 1: products
  logic        v1_q;
  logic [63:0] plo_q;
  logic [47:0] phi_q;
  logic [63:0] nprod_q;
  logic [63:0] bprod_q;
  logic [31:0] prior1_q;
  logic        last1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      plo_q    <= 64'(in_data_i.term_freq) * 64'(tf_scale_q[31:0]);
      phi_q    <= 48'(in_data_i.term_freq) * 48'(tf_scale_q[47:32]);
      nprod_q  <= 64'(in_data_i.doc_length) * 64'(mu_recip_q);
      bprod_q  <= 64'(const_boost_q) * 64'(in_data_i.item_boost);
      prior1_q <= in_data_i.prior_score;
      last1_q  <= in_data_i.last_in;
    end
  end

  // stage 2: log arguments and boost
  logic [79:0] wfull;
  logic [47:0] bsh;
  logic        v2_q;
  logic [63:0] xw_q;
  logic [63:0] xn_q;
  logic [31:0] boost2_q;
  logic [31:0] prior2_q;
  logic        last2_q;

  always_comb begin
    wfull = {16'd0, plo_q} + {phi_q, 32'd0};
    bsh   = bprod_q[63:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xw_q     <= (wfull[79:64] != 16'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : wfull[63:0];
      xn_q     <= {16'd0, nprod_q[63:16]};
      boost2_q <= !use_item_q ? const_boost_q
                : (bsh[47:32] != 16'd0) ? 32'hFFFF_FFFF : bsh[31:0];
      prior2_q <= prior1_q;
      last2_q  <= last1_q;
    end
  end

  logic [31:0] weight;
  logic [31:0] norm;

  dlm_log1p u_log_w (.clk_i, .en_i(en), .x_i(xw_q), .y_o(weight));
  dlm_log1p u_log_n (.clk_i, .en_i(en), .x_i(xn_q), .y_o(norm));

  // side data travels alongside the log units
  logic        vs_q     [0:LogLat-1];
  logic [31:0] boosts_q [0:LogLat-1];
  logic [31:0] priors_q [0:LogLat-1];
  logic        lasts_q  [0:LogLat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LogLat; k++) vs_q[k] <= 1'b0;
    end else if (en) begin
      vs_q[0] <= v2_q;
      for (int k = 1; k < LogLat; k++) vs_q[k] <= vs_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      boosts_q[0] <= boost2_q;
      priors_q[0] <= prior2_q;
      lasts_q[0]  <= last2_q;
      for (int k = 1; k < LogLat; k++) begin
        boosts_q[k] <= boosts_q[k-1];
        priors_q[k] <= priors_q[k-1];
        lasts_q[k]  <= lasts_q[k-1];
      end
    end
  end

  // stage D: difference, clamp at zero
  logic        v3_q;
  logic [31:0] w3_q;
  logic [31:0] boost3_q;
  logic [31:0] prior3_q;
  logic        last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= vs_q[LogLat-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w3_q     <= (weight > norm) ? weight - norm : 32'd0;
      boost3_q <= boosts_q[LogLat-1];
      prior3_q <= priors_q[LogLat-1];
      last3_q  <= lasts_q[LogLat-1];
    end
  end

  // stage E: apply boost
  logic [63:0] wprod;
  logic        v4_q;
  logic [31:0] w4_q;
  logic [31:0] prior4_q;
  logic        last4_q;

  assign wprod = 64'(w3_q) * 64'(boost3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w4_q     <= (wprod[63:48] != 16'd0) ? 32'hFFFF_FFFF : wprod[47:16];
      prior4_q <= prior3_q;
      last4_q  <= last3_q;
    end
  end

  // stage F: merge into output register
  logic [32:0] msum;
  logic [31:0] score_d;
  logic        out_valid_q;
  out_t        out_q;

  always_comb begin
    msum = {1'b0, prior4_q} + {1'b0, w4_q};
    unique case (merge_mode_q)
      MERGE_ADD: score_d = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
      MERGE_MAX: score_d = (prior4_q > w4_q) ? prior4_q : w4_q;
      default:   score_d = w4_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.score    <= score_d;
      out_q.last_out <= last4_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a held pipeline neither gains nor drops items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v4_q) && $stable(v3_q) && $stable(v1_q))
    else $error("pipeline valid moved while held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v4_q && (merge_mode_q == MERGE_ADD || merge_mode_q == MERGE_MAX)
    |=> out_q.score >= $past(prior4_q))
    else $error("merged score below prior");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v3_q |=> (w4_q == 32'd0) == ($past(w3_q) == 32'd0 || $past(boost3_q) == 32'd0
                                       || $past(wprod[63:16]) == 48'd0))
    else $error("boost stage zero mismatch");

endmodule
